@@ sv/ppg_pkg.sv @@
// Shared types and constants of the PPG peak-rate detector.
`default_nettype none

package ppg_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_DC_ALPHA     = 3'd0;
    localparam logic [2:0] CFG_PEAK_THR     = 3'd1;
    localparam logic [2:0] CFG_RELEASE_THR  = 3'd2;
    localparam logic [2:0] CFG_REFRACTORY   = 3'd3;
    localparam logic [2:0] CFG_MAX_INTERVAL = 3'd4;
    localparam logic [2:0] CFG_IRR_DELTA    = 3'd5;
    localparam logic [2:0] CFG_IRR_LIMIT    = 3'd6;

    // Shared divider widths
    localparam int DIV_W = 20;
    localparam int DSR_W = 16;

    // Rate constants, tenths of bpm
    localparam logic [DIV_W-1:0] RATE_NUM = 20'd600000;
    localparam logic [11:0]      RATE_MAX = 12'd2200;
    localparam logic [11:0]      RATE_MIN = 12'd300;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ sv/ppg_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module ppg_div
    import ppg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   trial;
    logic             ge;
    logic [DSR_W:0]   diff;
    logic [DSR_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        ge    = trial >= {1'b0, r_dsr};
        diff  = trial - {1'b0, r_dsr};
        n_rem = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                // shift one dividend bit in, subtract when it fits
                r_rem <= n_rem;
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(i_req.start))
        else $error("divider went busy without a start");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_dsr != '0) |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ sv/ppg_peak_rate_detector.sv @@
// Top level of the PPG peak-rate detector: filter, peak logic, rate sequencer.
//
// Usage: each transfer on the s_axis side carries one raw 18-bit IR sample and
// its millisecond timestamp. The block removes the baseline with a one-pole
// IIR filter (Q18.16 state), detects peaks with arm/release hysteresis and a
// refractory time, and turns each in-range interbeat interval into a rate in
// tenths of bpm. Every input gives exactly one m_axis transfer with the AC
// level, the beat flag, current and average rate and the irregular alert.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must do so only while the block is idle, which the block itself does
// not enforce. An index past the register list is dropped. A sample with a
// rate update runs the shared divider for 600000 / interval and, when the
// history holds a plausible rate, again for the history average; the history
// scan visits each entry in turn. s_axis_tready is high only while the
// sequencer is idle. A result waits in the output register; if the receiver
// stalls, the sequencer holds in its final step until the previous result is
// taken. Synchronous reset clears the filter, peak state, rate history and
// alert, and loads the register defaults.
`default_nettype none

module ppg_peak_rate_detector
    import ppg_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [17:0] i_cfg_data,
    // input samples
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // ir_sample[17:0], time_ms[49:18]
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // ac_level[18:0], beat_found[19],
                                             // current_rate_x10[31:20],
                                             // average_rate_x10[43:32],
                                             // irregular_alert[44]
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = 12 + $clog2(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_FILT  = 4'd2;
    localparam logic [3:0] S_AC    = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_RWAIT = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_AVG   = 4'd7;
    localparam logic [3:0] S_AWAIT = 4'd8;
    localparam logic [3:0] S_DEV   = 4'd9;
    localparam logic [3:0] S_CNT   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // configuration
    logic [15:0] r_alpha;
    logic [17:0] r_pk_thr;
    logic [17:0] r_rel_thr;
    logic [15:0] r_refr;
    logic [15:0] r_max_ibi;
    logic [11:0] r_irr_delta;
    logic [7:0]  r_irr_limit;

    // sequencer and working registers
    logic [3:0]         r_state;
    logic [17:0]        r_ir;
    logic [31:0]        r_now;
    logic [49:0]        r_prod_a;
    logic [34:0]        r_prod_b;
    logic signed [34:0] r_ac;
    logic [31:0]        r_since;
    logic               r_beat;
    logic [11:0]        r_rate;
    logic [IDX_W-1:0]   r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [11:0]        r_dev;
    t_div_req           r_div_req;
    t_div_rsp           div_rsp;

    // detector state
    logic [33:0]        r_base;
    logic               r_armed;
    logic [31:0]        r_last;
    logic [11:0]        r_hist [HISTORY_DEPTH];
    logic [IDX_W-1:0]   r_slot;
    logic [11:0]        r_cur;
    logic [11:0]        r_avg;
    logic [7:0]         r_dev_cnt;
    logic               r_alert;

    // output register
    logic               r_o_valid;
    logic [18:0]        r_o_ac;
    logic               r_o_beat;
    logic [11:0]        r_o_cur;
    logic [11:0]        r_o_avg;
    logic               r_o_alert;

    logic [16:0]        inv_alpha;
    logic               gt_peak;
    logic               lt_rel;
    logic               since_ok;
    logic [11:0]        hist_e;
    logic               hist_ok;
    logic [11:0]        n_rate;
    logic [IDX_W-1:0]   n_slot;
    logic [7:0]         n_cnt_up;
    logic [7:0]         n_cnt_dn;
    logic [18:0]        ac_int;
    logic               out_free;

    ppg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        inv_alpha = 17'h10000 - {1'b0, r_alpha};
        gt_peak   = r_ac > $signed({1'b0, r_pk_thr, 16'h0000});
        lt_rel    = r_ac < $signed({1'b0, r_rel_thr, 16'h0000});
        since_ok  = r_since > {16'h0000, r_refr};
        hist_e    = r_hist[r_idx];
        hist_ok   = (hist_e > RATE_MIN) && (hist_e < RATE_MAX);
        n_rate    = (div_rsp.quotient > {8'h00, RATE_MAX}) ? RATE_MAX
                                                            : div_rsp.quotient[11:0];
        n_slot    = (r_slot == IDX_LAST) ? '0 : r_slot + 1'b1;
        n_cnt_up  = (r_dev_cnt == 8'hFF) ? r_dev_cnt : r_dev_cnt + 8'd1;
        n_cnt_dn  = (r_dev_cnt == 8'h00) ? r_dev_cnt : r_dev_cnt - 8'd1;
        // integer part, truncated toward zero
        ac_int    = r_ac[34:16] + {18'h0, (r_ac[34] && (r_ac[15:0] != 16'h0000))};
        out_free  = !r_o_valid || m_axis_tready;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= 16'd62259;
            r_pk_thr    <= 18'd150;
            r_rel_thr   <= 18'd60;
            r_refr      <= 16'd300;
            r_max_ibi   <= 16'd2000;
            r_irr_delta <= 12'd200;
            r_irr_limit <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DC_ALPHA:     r_alpha     <= i_cfg_data[15:0];
                CFG_PEAK_THR:     r_pk_thr    <= i_cfg_data;
                CFG_RELEASE_THR:  r_rel_thr   <= i_cfg_data;
                CFG_REFRACTORY:   r_refr      <= i_cfg_data[15:0];
                CFG_MAX_INTERVAL: r_max_ibi   <= i_cfg_data[15:0];
                CFG_IRR_DELTA:    r_irr_delta <= i_cfg_data[11:0];
                CFG_IRR_LIMIT:    r_irr_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_div_req.start <= 1'b0;
            r_base          <= '0;
            r_armed         <= 1'b0;
            r_last          <= '0;
            r_slot          <= '0;
            r_cur           <= '0;
            r_avg           <= '0;
            r_dev_cnt       <= '0;
            r_alert         <= 1'b0;
            r_o_valid       <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_div_req.start <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ir    <= s_axis_tdata[17:0];
                        r_now   <= s_axis_tdata[49:18];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod_a <= {34'h0, r_alpha} * {16'h0, r_base};
                    r_prod_b <= {18'h0, inv_alpha} * {17'h0, r_ir};
                    r_state  <= S_FILT;
                end
                S_FILT: begin
                    // the input term already has 16 fraction bits, so only the feedback term is shifted
                    r_base  <= r_prod_a[49:16] + r_prod_b[33:0];
                    r_state <= S_AC;
                end
                S_AC: begin
                    r_ac    <= $signed({1'b0, r_ir, 16'h0000}) - $signed({1'b0, r_base});
                    r_since <= r_now - r_last;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (gt_peak && !r_armed && since_ok) begin
                        r_beat  <= 1'b1;
                        r_armed <= 1'b1;
                        r_last  <= r_now;
                        if (r_since < {16'h0000, r_max_ibi}) begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= RATE_NUM;
                            r_div_req.divisor  <= r_since[15:0];
                            r_state            <= S_RWAIT;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_beat <= 1'b0;
                        if (lt_rel) begin
                            r_armed <= 1'b0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_RWAIT: begin
                    if (div_rsp.done) begin
                        r_rate         <= n_rate;
                        r_hist[r_slot] <= n_rate;
                        r_slot         <= n_slot;
                        r_idx          <= '0;
                        r_sum          <= '0;
                        r_cnt          <= '0;
                        r_state        <= S_SUM;
                    end
                end
                S_SUM: begin
                    // scan one history entry a cycle, keep only plausible rates
                    if (hist_ok) begin
                        r_sum <= r_sum + {(SUM_W-12)'(0), hist_e};
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (r_cnt != '0) begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= DIV_W'(r_sum);
                        r_div_req.divisor  <= DSR_W'(r_cnt);
                        r_state            <= S_AWAIT;
                    end else begin
                        r_state <= S_DEV;
                    end
                end
                S_AWAIT: begin
                    if (div_rsp.done) begin
                        r_avg   <= div_rsp.quotient[11:0];
                        r_cur   <= r_rate;
                        r_state <= S_DEV;
                    end
                end
                S_DEV: begin
                    r_dev   <= (r_rate > r_avg) ? r_rate - r_avg : r_avg - r_rate;
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    if (r_dev > r_irr_delta) begin
                        r_dev_cnt <= n_cnt_up;
                        if (n_cnt_up >= r_irr_limit) begin
                            r_alert <= 1'b1;
                        end
                    end else begin
                        r_dev_cnt <= n_cnt_dn;
                        if (n_cnt_dn == 8'h00) begin
                            r_alert <= 1'b0;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_ac    <= ac_int;
                        r_o_beat  <= r_beat;
                        r_o_cur   <= r_cur;
                        r_o_avg   <= r_avg;
                        r_o_alert <= r_alert;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'b000, r_o_alert, r_o_avg, r_o_cur, r_o_beat, r_o_ac};

    a_alert_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alert |-> (r_dev_cnt != 8'h00))
        else $error("irregular alert raised with zero deviation count");

    a_rates_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_avg <= RATE_MAX) && (r_cur <= RATE_MAX))
        else $error("rate register above the rate ceiling");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_o_valid && !m_axis_tready) |=> (r_state == S_OUT))
        else $error("sequencer left its final step while the result was stalled");

endmodule

`default_nettype wire
